@@ hw/rtl/eitsc_pkg.sv @@
// Package for the Ethernet/IPv4/TCP service classifier.
// Holds the shared types, verdict codes, protocol constants and register map.
// Has no dependencies; every other file of the block imports it.
package eitsc_pkg;

  // Longest frame that is counted; later bytes are neither captured nor counted.
  localparam int unsigned MAX_FRAME_BYTES = 65535;
  localparam logic [15:0] MAX_INDEX = 16'(MAX_FRAME_BYTES);

  localparam logic [15:0] TYPE_VLAN    = 16'h8100;
  localparam logic [15:0] TYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [4:0]  ETH_HDR      = 5'd14;
  localparam logic [4:0]  ETH_VLAN_HDR = 5'd18;
  localparam logic [5:0]  TCP_MIN_HDR  = 6'd20;

  localparam logic [15:0] PORT_A_RESET = 16'd445;
  localparam logic [15:0] PORT_B_RESET = 16'd139;

  // Register map: word index taken from paddr[2].
  localparam logic REG_PORT_A = 1'b0;
  localparam logic REG_PORT_B = 1'b1;
  localparam int unsigned APB_ADDR_W = 3;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_SHORT    = 3'd1,
    VERDICT_NOT_IPV4 = 3'd2,
    VERDICT_NOT_TCP  = 3'd3,
    VERDICT_BAD_LEN  = 3'd4,
    VERDICT_PORT     = 3'd5
  } verdict_e;

  typedef struct packed {
    logic [15:0] port_a;
    logic [15:0] port_b;
  } cfg_t;

  // Per-frame parse state; also the snapshot handed to the judge stage.
  typedef struct packed {
    logic [15:0] len;        // bytes counted so far
    logic        vlan;       // one 802.1Q tag seen, IP header starts at 18
    logic        ipv4;       // final EtherType is IPv4
    logic        ip_tcp;     // IP protocol byte is TCP
    logic [3:0]  ihl;
    logic [3:0]  tcp_words;
    logic [15:0] total_len;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] tcp_sport;
    logic [15:0] tcp_dport;
    logic [31:0] seq;
  } parse_t;

  // Result item, last declared field (verdict) in the lowest bits, padded to whole bytes.
  typedef struct packed {
    logic [3:0]  pad;
    logic [15:0] payload_length;
    logic [7:0]  payload_offset;
    logic [31:0] sequence_number;
    logic [15:0] server_port;
    logic [31:0] server_address;
    logic [15:0] client_port;
    logic [31:0] client_address;
    logic        to_client;
    verdict_e    verdict;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

@@ hw/rtl/eitsc_cfg.sv @@
// Configuration registers of the service classifier: the two service ports.
// APB-style slave, always ready. Depends on eitsc_pkg.
module eitsc_cfg
  import eitsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_PORT_A: cfg_d.port_a = pwdata[15:0];
        REG_PORT_B: cfg_d.port_b = pwdata[15:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PORT_A: prdata = {16'd0, cfg_q.port_a};
      REG_PORT_B: prdata = {16'd0, cfg_q.port_b};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.port_a <= PORT_A_RESET;
      cfg_q.port_b <= PORT_B_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/eitsc_parser.sv @@
// Input register and byte-indexed header capture of the service classifier.
// On the last byte the final parse state is copied to a snapshot register
// and the frame state returns to reset. Depends on eitsc_pkg.
module eitsc_parser
  import eitsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       judge_ready_i,
  output logic       snap_valid_o,
  output parse_t     snap_o
);

  logic        byte_valid_q, byte_valid_d;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        go;
  logic        snap_free;

  parse_t      st_q, st_d, cur;
  parse_t      snap_q, snap_d;
  logic        snap_valid_q, snap_valid_d;
  logic [7:0]  etype_hi_q, etype_hi_d;

  logic [15:0] idx;
  logic [4:0]  ip_start;
  logic [15:0] r;
  logic [3:0]  ihl_n;
  logic [6:0]  tcp_start;
  logic [15:0] t;

  // A last byte may only advance when the snapshot slot is free.
  assign snap_free = !snap_valid_q || judge_ready_i;
  assign go        = byte_valid_q && (!last_q || snap_free);
  assign in_ready_o = !byte_valid_q || go;

  always_comb begin
    byte_valid_d = byte_valid_q;
    if (in_ready_o) begin
      byte_valid_d = in_valid_i;
    end
  end

  always_comb begin
    cur        = st_q;
    etype_hi_d = etype_hi_q;
    idx        = st_q.len;
    ip_start   = st_q.vlan ? ETH_VLAN_HDR : ETH_HDR;
    r          = idx - {11'd0, ip_start};
    ihl_n      = st_q.ihl;
    if (idx >= {11'd0, ip_start} && r == 16'd0) begin
      ihl_n = byte_q[3:0];
    end
    tcp_start  = {2'b00, ip_start} + {1'b0, ihl_n, 2'b00};
    t          = idx - {9'd0, tcp_start};

    if (go && idx != MAX_INDEX) begin
      cur.len = idx + 16'd1;
      if (idx == 16'd12) begin
        etype_hi_d = byte_q;
      end
      if (idx == 16'd13) begin
        if ({etype_hi_q, byte_q} == TYPE_VLAN) begin
          cur.vlan = 1'b1;
        end else begin
          cur.ipv4 = ({etype_hi_q, byte_q} == TYPE_IPV4);
        end
      end
      if (st_q.vlan) begin
        if (idx == 16'd16) begin
          etype_hi_d = byte_q;
        end
        if (idx == 16'd17) begin
          cur.ipv4 = ({etype_hi_q, byte_q} == TYPE_IPV4);
        end
      end
      // IP header fields, by offset from the start of the IP header.
      if (idx >= {11'd0, ip_start}) begin
        cur.ihl = ihl_n;
        if (r == 16'd2) begin
          cur.total_len = {byte_q, 8'd0};
        end
        if (r == 16'd3) begin
          cur.total_len = {st_q.total_len[15:8], byte_q};
        end
        if (r == 16'd9) begin
          cur.ip_tcp = (byte_q == PROTO_TCP);
        end
        if (r >= 16'd12 && r < 16'd16) begin
          cur.src_addr = {st_q.src_addr[23:0], byte_q};
        end
        if (r >= 16'd16 && r < 16'd20) begin
          cur.dst_addr = {st_q.dst_addr[23:0], byte_q};
        end
        // TCP header fields; may overlap the IP header for tiny IHL values.
        if (idx >= {9'd0, tcp_start}) begin
          if (t < 16'd2) begin
            cur.tcp_sport = {st_q.tcp_sport[7:0], byte_q};
          end
          if (t >= 16'd2 && t < 16'd4) begin
            cur.tcp_dport = {st_q.tcp_dport[7:0], byte_q};
          end
          if (t >= 16'd4 && t < 16'd8) begin
            cur.seq = {st_q.seq[23:0], byte_q};
          end
          if (t == 16'd12) begin
            cur.tcp_words = byte_q[7:4];
          end
        end
      end
    end
    // The saved EtherType byte never carries over into the next frame.
    if (go && last_q) begin
      etype_hi_d = 8'd0;
    end
  end

  always_comb begin
    st_d         = cur;
    snap_d       = snap_q;
    snap_valid_d = snap_valid_q && !judge_ready_i;
    if (go && last_q) begin
      snap_d       = cur;
      snap_valid_d = 1'b1;
      st_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
      snap_valid_q <= 1'b0;
      st_q         <= '0;
      etype_hi_q   <= 8'd0;
    end else begin
      byte_valid_q <= byte_valid_d;
      snap_valid_q <= snap_valid_d;
      st_q         <= st_d;
      etype_hi_q   <= etype_hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
    snap_q <= snap_d;
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

@@ hw/rtl/eitsc_judge.sv @@
// Verdict and result formatting of the service classifier.
// Judges one frame snapshot and holds the result in the output register.
// Depends on eitsc_pkg.
module eitsc_judge
  import eitsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                snap_valid_i,
  input  parse_t              snap_i,
  output logic                judge_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RESULT_W-1:0] out_data_o
);

  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;
  logic        out_free;

  logic [4:0]  ip_start;
  logic [5:0]  ihl4;
  logic [5:0]  tcp4;
  logic [5:0]  tcp_hdr;
  logic [7:0]  tcp_end;
  logic [6:0]  hdr_sum;
  logic        src_svc;
  logic        dst_svc;
  verdict_e    verdict;

  assign out_free      = !out_valid_q || out_ready_i;
  assign judge_ready_o = out_free;

  always_comb begin
    ip_start = snap_i.vlan ? ETH_VLAN_HDR : ETH_HDR;
    ihl4     = {snap_i.ihl, 2'b00};
    tcp4     = {snap_i.tcp_words, 2'b00};
    tcp_hdr  = (tcp4 > TCP_MIN_HDR) ? tcp4 : TCP_MIN_HDR;
    tcp_end  = {3'd0, ip_start} + {2'd0, ihl4} + {2'd0, tcp_hdr};
    hdr_sum  = {1'b0, ihl4} + {1'b0, tcp4};
    src_svc  = (snap_i.tcp_sport == cfg_i.port_a) || (snap_i.tcp_sport == cfg_i.port_b);
    dst_svc  = (snap_i.tcp_dport == cfg_i.port_a) || (snap_i.tcp_dport == cfg_i.port_b);

    if (snap_i.len < {11'd0, ETH_HDR}) begin
      verdict = VERDICT_SHORT;
    end else if (snap_i.vlan && snap_i.len < {11'd0, ETH_VLAN_HDR}) begin
      verdict = VERDICT_NOT_IPV4;
    end else if (!snap_i.ipv4) begin
      verdict = VERDICT_NOT_IPV4;
    end else if (snap_i.len < {11'd0, ip_start} + 16'd10) begin
      verdict = VERDICT_SHORT;
    end else if (!snap_i.ip_tcp) begin
      verdict = VERDICT_NOT_TCP;
    end else if (snap_i.len < {8'd0, tcp_end}) begin
      verdict = VERDICT_SHORT;
    end else if (snap_i.total_len < {9'd0, hdr_sum}) begin
      verdict = VERDICT_BAD_LEN;
    end else if (!src_svc && !dst_svc) begin
      verdict = VERDICT_PORT;
    end else begin
      verdict = VERDICT_OK;
    end

    res_d         = '0;
    res_d.verdict = verdict;
    if (verdict == VERDICT_OK) begin
      // When both ports are service ports the source port decides.
      res_d.to_client       = src_svc;
      res_d.client_address  = src_svc ? snap_i.dst_addr : snap_i.src_addr;
      res_d.client_port     = src_svc ? snap_i.tcp_dport : snap_i.tcp_sport;
      res_d.server_address  = src_svc ? snap_i.src_addr : snap_i.dst_addr;
      res_d.server_port     = src_svc ? snap_i.tcp_sport : snap_i.tcp_dport;
      res_d.sequence_number = snap_i.seq;
      res_d.payload_offset  = {3'd0, ip_start} + {2'd0, ihl4} + {2'd0, tcp4};
      res_d.payload_length  = snap_i.total_len - {9'd0, hdr_sum};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = snap_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && snap_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

@@ hw/rtl/eth_ipv4_tcp_service_classifier.sv @@
// Top level of the Ethernet/IPv4/TCP service classifier.
// Instantiates the configuration registers, the parser and the judge stage.
// Depends on eitsc_pkg, eitsc_cfg, eitsc_parser and eitsc_judge.
//
// Usage: a captured frame enters on the slave stream one byte per transfer,
// in wire order, with s_axis_tlast on its final byte. One optional 802.1Q
// tag is skipped; the frame must carry IPv4 and TCP. For every frame exactly
// one result transfer leaves on the master stream, after the last byte. The
// result carries a verdict and, for accepted frames, the client/server
// addresses and ports, the TCP sequence number and the payload offset and
// length; for rejected frames all fields but the verdict are zero.
//
// Timing: a byte passes an input register, the capture logic with a snapshot
// register, and the judge logic with the output register, from which its
// result leaves. One byte is taken every cycle while s_axis_tready is high;
// if m_axis_tready is held low, bytes flow until a last byte finds both the
// snapshot and output registers occupied, and s_axis_tready drops until space
// frees. Reset empties the pipeline and sets the service ports to 445 and 139;
// they are written over the APB port at addresses 0 and 4, by the user only
// while idle: the block itself does not enforce it.
module eth_ipv4_tcp_service_classifier
  import eitsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input bytes.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] frame_byte
  input  logic                  s_axis_tlast,   // frame_last
  // Results.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] verdict, [3] to_client, [35:4] client_address, [51:36] client_port,
  // [83:52] server_address, [99:84] server_port, [131:100] sequence_number,
  // [139:132] payload_offset, [155:140] payload_length, [159:156] zero
  output logic [RESULT_W-1:0]   m_axis_tdata,
  // Configuration.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t   cfg;
  parse_t snap;
  logic   snap_valid;
  logic   judge_ready;

  eitsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Byte capture: updates the frame state by byte index and snapshots it
  // on the last byte.
  eitsc_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_byte_i     (s_axis_tdata),
    .in_last_i     (s_axis_tlast),
    .judge_ready_i (judge_ready),
    .snap_valid_o  (snap_valid),
    .snap_o        (snap)
  );

  // Verdict and field selection into the output register.
  eitsc_judge u_judge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .snap_valid_i  (snap_valid),
    .snap_i        (snap),
    .judge_ready_o (judge_ready),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata)
  );

endmodule
